// File: rtl/smoothed_temp_to_gauge_steps_core_defines.svh
// ----------------------------------------------------------------------------
// Smoothed temperature to gauge steps: assertion macros
// Concurrent check wrappers sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_TEMP_TO_GAUGE_STEPS_CORE_DEFINES_SVH
`define SMOOTHED_TEMP_TO_GAUGE_STEPS_CORE_DEFINES_SVH

// same-cycle implication
`define STGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stgs_pkg.sv
// ----------------------------------------------------------------------------
// Smoothed temperature to gauge steps: shared package
// Widths, reset values, register indexes, transaction and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stgs_pkg;

  localparam int TEMP_W     = 16;
  localparam int STEP_W     = 16;
  localparam int FRAC_X     = 8;
  localparam int AVG_W      = TEMP_W + FRAC_X;
  localparam int DIFF_W     = AVG_W + 1;
  localparam int DEN_W      = TEMP_W + FRAC_X;
  localparam int DSR_W      = DEN_W + 1;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int QUO_W      = 18;
  localparam int SUM_W      = DSR_W + QUO_W;
  localparam int CNT_W      = $clog2(QUO_W);
  localparam int RND_SHIFT  = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [MUL_B_W-1:0] ALPHA_Q16 = 17'sd9830;
  localparam logic signed [PROD_W-1:0]  RND_POS   = 42'sd32768;
  localparam logic signed [PROD_W-1:0]  RND_NEG   = 42'sd32767;
  localparam logic [QUO_W-1:0]          QUO_POS_MAX = 18'd32767;
  localparam logic [QUO_W-1:0]          QUO_NEG_MAX = 18'd32768;
  localparam logic signed [STEP_W-1:0]  STEP_MAX  = 16'sd32767;
  localparam logic signed [STEP_W-1:0]  STEP_MIN  = -16'sd32768;

  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST  = 16'sd0;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST  = 16'sd1920;
  localparam logic signed [STEP_W-1:0] MIN_STEPS_RST = 16'sd0;
  localparam logic signed [STEP_W-1:0] MAX_STEPS_RST = 16'sd945;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_TEMP  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TEMP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_STEPS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_STEPS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT    = 3'd4;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_value;
    logic                     temp_invalid;
  } in_item_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] target_steps;
    logic signed [TEMP_W-1:0] smoothed_temp;
  } out_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [STEP_W-1:0] min_steps;
    logic signed [STEP_W-1:0] max_steps;
    logic                     invert_direction;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_STEP,
    ST_CLAMP,
    ST_MSPAN,
    ST_MSMIN,
    ST_SUM,
    ST_ABS,
    ST_NUM,
    ST_DIV,
    ST_SAT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_avg;
    logic diff;
    logic mul_alpha;
    logic step;
    logic clamp;
    logic mul_span;
    logic mul_smin;
    logic sum;
    logic absval;
    logic num;
    logic div_step;
    logic sat;
    logic load_smin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic have_sample;
    logic span_ok;
    logic out_blocked;
  } sts_t;

endpackage

// File: rtl/stgs_datapath.sv
// ----------------------------------------------------------------------------
// Smoothed temperature to gauge steps: datapath
// Input clamp, moving average update, shared multiplier, linear mapping,
// restoring divider with rounding and saturation, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stgs_datapath import stgs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  logic signed [AVG_W-1:0]   tgt_r, tgt_nxt;
  logic signed [AVG_W-1:0]   avg_r, avg_nxt;
  logic                      have_r, have_nxt;
  logic signed [DIFF_W-1:0]  d_r, d_nxt;
  logic [DEN_W-1:0]          a_r, a_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [PROD_W-1:0]  acc_r, acc_nxt;
  logic signed [SUM_W-1:0]   s_r, s_nxt;
  logic [SUM_W-1:0]          mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [DSR_W-1:0]          rem_r, rem_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic signed [STEP_W-1:0]  res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic signed [TEMP_W-1:0]  t_in, tmin, tmax, t_sel;
  logic signed [AVG_W-1:0]   lo, hi, avg_c;
  logic signed [TEMP_W:0]    tdiff, sdiff;
  logic [TEMP_W:0]           span_mag;
  logic [DEN_W-1:0]          den;
  logic [DSR_W-1:0]          dsr;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p, rnd;
  logic [SUM_W-1:0]          num_w;
  logic [DSR_W:0]            trial;
  logic                      ge;

  assign t_in = in_data.temp_value;
  assign tmin = cfg.min_temp;
  assign tmax = cfg.max_temp;

  always_comb begin
    if (in_data.temp_invalid) begin
      t_sel = tmin;
    end else if (t_in < tmin) begin
      t_sel = tmin;
    end else if (t_in > tmax) begin
      t_sel = tmax;
    end else begin
      t_sel = t_in;
    end
  end

  assign lo    = {tmin, {FRAC_X{1'b0}}};
  assign hi    = {tmax, {FRAC_X{1'b0}}};
  assign tdiff = $signed({tmax[TEMP_W-1], tmax}) - $signed({tmin[TEMP_W-1], tmin});
  assign sdiff = $signed({cfg.max_steps[STEP_W-1], cfg.max_steps})
               - $signed({cfg.min_steps[STEP_W-1], cfg.min_steps});
  assign span_mag = sdiff[TEMP_W] ? (TEMP_W+1)'(-sdiff) : sdiff;
  assign den      = {tdiff[TEMP_W-1:0], {FRAC_X{1'b0}}};
  assign dsr      = {den, 1'b0};

  always_comb begin
    if (avg_r < lo) begin
      avg_c = lo;
    end else if (avg_r > hi) begin
      avg_c = hi;
    end else begin
      avg_c = avg_r;
    end
  end

  always_comb begin
    if (cmd.mul_span) begin
      mul_a = $signed({1'b0, a_r});
      mul_b = $signed(span_mag);
    end else if (cmd.mul_smin) begin
      mul_a = $signed({1'b0, den});
      mul_b = $signed({cfg.min_steps[STEP_W-1], cfg.min_steps});
    end else begin
      mul_a = d_r;
      mul_b = ALPHA_Q16;
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd   = prod_r + (prod_r[PROD_W-1] ? RND_NEG : RND_POS);
  assign num_w = {mag_r[SUM_W-2:0], 1'b0} + SUM_W'(den);
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_comb begin
    tgt_nxt       = tgt_r;
    avg_nxt       = avg_r;
    have_nxt      = have_r;
    d_nxt         = d_r;
    a_nxt         = a_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.capture) begin
      tgt_nxt = {t_sel, {FRAC_X{1'b0}}};
    end
    if (cmd.load_avg) begin
      avg_nxt  = tgt_r;
      have_nxt = 1'b1;
    end
    if (cmd.diff) begin
      d_nxt = DIFF_W'(tgt_r) - DIFF_W'(avg_r);
    end
    if (cmd.mul_alpha || cmd.mul_span || cmd.mul_smin) begin
      prod_nxt = mul_p;
    end
    if (cmd.step) begin
      avg_nxt = avg_r + rnd[RND_SHIFT +: AVG_W];
    end
    if (cmd.clamp) begin
      a_nxt = DEN_W'(avg_c - lo);
    end
    if (cmd.mul_smin) begin
      acc_nxt = cfg.invert_direction ? -prod_r : prod_r;
    end
    if (cmd.sum) begin
      s_nxt = SUM_W'(acc_r) + SUM_W'(prod_r);
    end
    if (cmd.absval) begin
      neg_nxt = s_r[SUM_W-1];
      mag_nxt = s_r[SUM_W-1] ? SUM_W'(-s_r) : s_r;
    end
    if (cmd.num) begin
      rem_nxt = num_w[SUM_W-1 -: DSR_W];
      quo_nxt = num_w[QUO_W-1:0];
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.sat) begin
      if (neg_r) begin
        res_nxt = (quo_r > QUO_NEG_MAX) ? STEP_MIN : STEP_W'(QUO_W'(0) - quo_r);
      end else begin
        res_nxt = (quo_r > QUO_POS_MAX) ? STEP_MAX : quo_r[STEP_W-1:0];
      end
    end
    if (cmd.load_smin) begin
      res_nxt = cfg.min_steps;
    end
    if (cmd.load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.target_steps  = res_r;
      out_data_nxt.smoothed_temp = avg_r[AVG_W-1 -: TEMP_W];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      avg_r       <= {MIN_TEMP_RST, {FRAC_X{1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    d_r        <= d_nxt;
    a_r        <= a_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    s_r        <= s_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.have_sample = have_r;
  assign sts.span_ok     = !tdiff[TEMP_W] && (tdiff != '0);
  assign sts.out_blocked = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// File: rtl/stgs_ctrl.sv
// ----------------------------------------------------------------------------
// Smoothed temperature to gauge steps: controller
// Sequences one transaction through update, mapping and division steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stgs_ctrl import stgs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts.have_sample) begin
          cmd.diff  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          cmd.load_avg = 1'b1;
          state_nxt    = ST_CLAMP;
        end
      end
      ST_MUL: begin
        cmd.mul_alpha = 1'b1;
        state_nxt     = ST_STEP;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (sts.span_ok) begin
          cmd.clamp = 1'b1;
          state_nxt = ST_MSPAN;
        end else begin
          cmd.load_smin = 1'b1;
          state_nxt     = ST_FIN;
        end
      end
      ST_MSPAN: begin
        cmd.mul_span = 1'b1;
        state_nxt    = ST_MSMIN;
      end
      ST_MSMIN: begin
        cmd.mul_smin = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_nxt  = ST_NUM;
      end
      ST_NUM: begin
        cmd.num   = 1'b1;
        cnt_nxt   = CNT_W'(QUO_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_blocked) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/smoothed_temp_to_gauge_steps_core.sv
// ----------------------------------------------------------------------------
// Smoothed temperature to gauge steps: top level
// Maps smoothed temperature readings onto gauge needle step targets.
// ----------------------------------------------------------------------------
// Usage:
//   Readings enter on in_valid/in_stall/in_data; each accepted transaction
//   yields exactly one result on out_valid/out_stall/out_data.
//   The user writes registers through cfg_we/cfg_addr/cfg_wdata only while
//   idle; the block does not enforce this. Indexes beyond the invert flag
//   are ignored.
//   The 18-step restoring divider that forms the rounded step target
//   dominates each transaction; the first reading after reset skips the
//   smoothing update, and a reading with an empty or reversed temperature
//   span skips the mapping and division.
//   in_stall is high from acceptance until the result is loaded into the
//   output register, so a new reading is taken while a result still waits.
//   While the receiver stalls, the finished result holds and a second result
//   waits in the datapath until the output register frees.
//   Synchronous reset restores the register defaults, clears the sample
//   flag and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "smoothed_temp_to_gauge_steps_core_defines.svh"

module smoothed_temp_to_gauge_steps_core import stgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t ctrl_cmd;
  sts_t dp_sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_TEMP:  cfg_nxt.min_temp         = cfg_wdata;
        REG_MAX_TEMP:  cfg_nxt.max_temp         = cfg_wdata;
        REG_MIN_STEPS: cfg_nxt.min_steps        = cfg_wdata;
        REG_MAX_STEPS: cfg_nxt.max_steps        = cfg_wdata;
        REG_INVERT:    cfg_nxt.invert_direction = cfg_wdata[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_temp         <= MIN_TEMP_RST;
      cfg_r.max_temp         <= MAX_TEMP_RST;
      cfg_r.min_steps        <= MIN_STEPS_RST;
      cfg_r.max_steps        <= MAX_STEPS_RST;
      cfg_r.invert_direction <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctrl_cmd)
  );

  stgs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `STGS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
  `STGS_ASSERT_NOW(a_out_from_load, $rose(out_valid), $past(ctrl_cmd.load_out), "stray result")
  `STGS_ASSERT_NOW(a_no_overwrite, ctrl_cmd.load_out, !(out_valid && out_stall), "result lost")

endmodule
